// ----- design/ofs_pkg.sv -----
`default_nettype none

package ofs_pkg;

  // Default sizing of the sample path and the averaging window
  localparam int unsigned SAMPLE_BITS_DEF     = 10;
  localparam int unsigned AVERAGE_SAMPLES_DEF = 16;

  // Tick counters and the pulse tally have fixed widths
  localparam int unsigned CNT_W = 10;
  localparam int unsigned TOT_W = 5;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_THRESH    = 3'd0,
    REG_AMBIENT_DROP    = 3'd1,
    REG_MIN_FIRE_GAP    = 3'd2,
    REG_MAX_FIRE_GAP    = 3'd3,
    REG_WIDTH_LIMIT     = 3'd4,
    REG_COUNT_LIMIT     = 3'd5,
    REG_FIRE_HOLDOFF    = 3'd6
  } cfg_reg_e;

  // Register reset values
  localparam logic [CNT_W-1:0] LIGHT_THRESH_RST    = 10'd40;
  localparam logic [CNT_W-1:0] AMBIENT_DROP_RST    = 10'd10;
  localparam logic [CNT_W-1:0] MIN_FIRE_GAP_RST    = 10'd45;
  localparam logic [CNT_W-1:0] MAX_FIRE_GAP_RST    = 10'd100;
  localparam logic [CNT_W-1:0] WIDTH_LIMIT_RST     = 10'd500;
  localparam logic [TOT_W-1:0] COUNT_LIMIT_RST     = 5'd20;
  localparam logic [CNT_W-1:0] FIRE_HOLDOFF_RST    = 10'd376;

  typedef struct packed {
    logic [CNT_W-1:0] light_thresh;
    logic [CNT_W-1:0] ambient_drop;
    logic [CNT_W-1:0] min_fire_gap;
    logic [CNT_W-1:0] max_fire_gap;
    logic [CNT_W-1:0] width_limit;
    logic [TOT_W-1:0] count_limit;
    logic [CNT_W-1:0] fire_holdoff;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/ofs_cfg_regs.sv -----
`default_nettype none

module ofs_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [ofs_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  wire logic [ofs_pkg::CFG_DATA_W-1:0] wr_data_i,
  output ofs_pkg::cfg_t                       cfg_o
);

  ofs_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (ofs_pkg::cfg_reg_e'(wr_index_i))
        ofs_pkg::REG_LIGHT_THRESH:    cfg_d.light_thresh    = wr_data_i;
        ofs_pkg::REG_AMBIENT_DROP:    cfg_d.ambient_drop    = wr_data_i;
        ofs_pkg::REG_MIN_FIRE_GAP:    cfg_d.min_fire_gap    = wr_data_i;
        ofs_pkg::REG_MAX_FIRE_GAP:    cfg_d.max_fire_gap    = wr_data_i;
        ofs_pkg::REG_WIDTH_LIMIT:     cfg_d.width_limit     = wr_data_i;
        ofs_pkg::REG_COUNT_LIMIT:
          cfg_d.count_limit = wr_data_i[ofs_pkg::TOT_W-1:0];
        ofs_pkg::REG_FIRE_HOLDOFF:    cfg_d.fire_holdoff    = wr_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_thresh    <= ofs_pkg::LIGHT_THRESH_RST;
      cfg_q.ambient_drop    <= ofs_pkg::AMBIENT_DROP_RST;
      cfg_q.min_fire_gap    <= ofs_pkg::MIN_FIRE_GAP_RST;
      cfg_q.max_fire_gap    <= ofs_pkg::MAX_FIRE_GAP_RST;
      cfg_q.width_limit     <= ofs_pkg::WIDTH_LIMIT_RST;
      cfg_q.count_limit     <= ofs_pkg::COUNT_LIMIT_RST;
      cfg_q.fire_holdoff    <= ofs_pkg::FIRE_HOLDOFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/ofs_core.sv -----
`default_nettype none

module ofs_core #(
  parameter int unsigned SAMPLE_BITS     = ofs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned AVERAGE_SAMPLES = ofs_pkg::AVERAGE_SAMPLES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     step_i,
  input  wire logic [SAMPLE_BITS-1:0]   sample_i,
  input  wire ofs_pkg::cfg_t            cfg_i,
  output logic                          fire_o,
  output logic [SAMPLE_BITS-1:0]        ambient_o,
  output logic [ofs_pkg::TOT_W-1:0]     total_o,
  output logic                          calib_o,
  output logic                          pulse_o
);

  localparam int unsigned IDX_W = (AVERAGE_SAMPLES > 1) ? $clog2(AVERAGE_SAMPLES) : 1;
  localparam int unsigned SUM_W = SAMPLE_BITS + IDX_W;
  // Divide by the window length as a multiply by a rounded-up reciprocal
  localparam int unsigned SHIFT = SUM_W + IDX_W;
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((64'd1 << SHIFT) + 64'(AVERAGE_SAMPLES) - 64'd1) / 64'(AVERAGE_SAMPLES));
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVERAGE_SAMPLES - 1);
  // Compare width covering both sample and register ranges plus a carry
  localparam int unsigned CW =
    ((SAMPLE_BITS > ofs_pkg::CNT_W) ? SAMPLE_BITS : ofs_pkg::CNT_W) + 1;

  logic [SAMPLE_BITS-1:0]      ambient_q, ambient_d;
  logic [SUM_W-1:0]            sum_q, sum_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic                        calib_q, calib_d;
  logic                        pulse_q, pulse_d;
  logic [ofs_pkg::CNT_W-1:0]   width_q, width_d;
  logic [ofs_pkg::TOT_W-1:0]   total_q, total_d;
  logic [ofs_pkg::CNT_W-1:0]   gap_q, gap_d;
  logic [ofs_pkg::CNT_W-1:0]   holdoff_q, holdoff_d;
  logic                        fire_d;

  logic [SUM_W-1:0]            sum_add;
  logic [2*SUM_W:0]            product;
  logic [SAMPLE_BITS-1:0]      quotient;
  logic [ofs_pkg::CNT_W-1:0]   gap_inc;
  logic [ofs_pkg::CNT_W-1:0]   width_inc;
  logic [ofs_pkg::TOT_W-1:0]   total_kept;
  logic                        above;
  logic                        below;

  // Light level relative to ambient
  assign above = CW'(sample_i) > (CW'(ambient_q) + CW'(cfg_i.light_thresh));
  assign below = (CW'(sample_i) + CW'(cfg_i.ambient_drop)) < CW'(ambient_q);

  // Running sum and its average
  assign sum_add  = sum_q + SUM_W'(sample_i);
  assign product  = (2*SUM_W+1)'(sum_add) * (2*SUM_W+1)'(RECIP);
  assign quotient = product[SHIFT +: SAMPLE_BITS];

  // Saturating tick counters
  assign gap_inc   = (!pulse_q && gap_q != ofs_pkg::CNT_MAX) ? gap_q + 1'b1 : gap_q;
  assign width_inc = (width_q != ofs_pkg::CNT_MAX) ? width_q + 1'b1 : width_q;
  assign total_kept = (total_q != '0 && gap_inc > cfg_i.max_fire_gap) ? '0 : total_q;

  // One tick of the trigger
  always_comb begin
    ambient_d = ambient_q;
    sum_d     = sum_q;
    idx_d     = idx_q;
    calib_d   = calib_q;
    pulse_d   = pulse_q;
    width_d   = width_q;
    total_d   = total_q;
    gap_d     = gap_inc;
    holdoff_d = holdoff_q;
    fire_d    = 1'b0;
    if (holdoff_q != '0) begin
      holdoff_d = holdoff_q - 1'b1;
    end else if (calib_q) begin
      if (idx_q == IDX_LAST) begin
        ambient_d = quotient;
        calib_d   = 1'b0;
        sum_d     = '0;
        idx_d     = '0;
      end else begin
        sum_d = sum_add;
        idx_d = idx_q + 1'b1;
      end
    end else if (pulse_q) begin
      width_d = width_inc;
      if (!above) begin
        pulse_d = 1'b0;
        gap_d   = '0;
        total_d = (total_q != ofs_pkg::TOT_MAX) ? total_q + 1'b1 : total_q;
      end else if (width_inc >= cfg_i.width_limit) begin
        // pulse too long: treat as a change of ambient
        pulse_d = 1'b0;
        gap_d   = '0;
        total_d = '0;
        calib_d = 1'b1;
        sum_d   = '0;
        idx_d   = '0;
      end
    end else begin
      if (total_q != '0 && above &&
          gap_inc > cfg_i.min_fire_gap && gap_inc < cfg_i.max_fire_gap) begin
        fire_d    = 1'b1;
        total_d   = '0;
        holdoff_d = cfg_i.fire_holdoff;
      end else begin
        total_d = total_kept;
        if (below || total_kept > cfg_i.count_limit) begin
          calib_d = 1'b1;
          sum_d   = '0;
          idx_d   = '0;
        end else if (above) begin
          pulse_d = 1'b1;
          width_d = '0;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_q <= '0;
      sum_q     <= '0;
      idx_q     <= '0;
      calib_q   <= 1'b1;
      pulse_q   <= 1'b0;
      width_q   <= '0;
      total_q   <= '0;
      gap_q     <= '0;
      holdoff_q <= '0;
    end else if (step_i) begin
      ambient_q <= ambient_d;
      sum_q     <= sum_d;
      idx_q     <= idx_d;
      calib_q   <= calib_d;
      pulse_q   <= pulse_d;
      width_q   <= width_d;
      total_q   <= total_d;
      gap_q     <= gap_d;
      holdoff_q <= holdoff_d;
    end
  end

  // Result word shows the state after the tick
  assign fire_o    = fire_d;
  assign ambient_o = ambient_d;
  assign total_o   = total_d;
  assign calib_o   = calib_d;
  assign pulse_o   = pulse_d;

  // A fire always loads the holdoff and clears the tally
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && fire_d |=> holdoff_q == $past(cfg_i.fire_holdoff) && total_q == '0)
    else $error("fire did not load holdoff");

  // Calibration and an open pulse never coexist
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(calib_q && pulse_q))
    else $error("pulse open during calibration");

  // While holding off, nothing but the holdoff and gap moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && holdoff_q != '0 |=> $stable(total_q) && $stable(calib_q) && $stable(ambient_q))
    else $error("state changed during holdoff");

endmodule

`default_nettype wire

// ----- design/optical_slave_flash_trigger.sv -----
// Path: each sample word passes the input register, then the result register.
// Throughput: one word per cycle while out_ready_i is high; one trigger pass per sample.
// Reset: asynchronous, active low; clears the pipeline, loads register defaults, zeroes the
//   ambient level and starts the initial calibration over the first AVERAGE_SAMPLES words.
// The config port is always ready; writes take effect from the next word onward.
`default_nettype none

module optical_slave_flash_trigger #(
  parameter int unsigned SAMPLE_BITS     = ofs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned AVERAGE_SAMPLES = ofs_pkg::AVERAGE_SAMPLES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]         sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                fire_o,
  output logic [SAMPLE_BITS-1:0]              ambient_level_o,
  output logic [ofs_pkg::TOT_W-1:0]           pulses_seen_o,
  output logic                                calibrating_now_o,
  output logic                                pulse_active_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ofs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ofs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ofs_pkg::cfg_t               cfg;
  logic                        in_valid_q;
  logic [SAMPLE_BITS-1:0]      sample_q;
  logic                        out_valid_q;
  logic                        fire_q;
  logic [SAMPLE_BITS-1:0]      ambient_q;
  logic [ofs_pkg::TOT_W-1:0]   total_q;
  logic                        calib_q;
  logic                        pulse_q;
  logic                        step;
  logic                        fire_d;
  logic [SAMPLE_BITS-1:0]      ambient_d;
  logic [ofs_pkg::TOT_W-1:0]   total_d;
  logic                        calib_d;
  logic                        pulse_d;

  assign cfg_ready_o = 1'b1;

  ofs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Step when a word is held and the result register is free or draining
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  ofs_core #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .AVERAGE_SAMPLES (AVERAGE_SAMPLES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .sample_i  (sample_q),
    .cfg_i     (cfg),
    .fire_o    (fire_d),
    .ambient_o (ambient_d),
    .total_o   (total_d),
    .calib_o   (calib_d),
    .pulse_o   (pulse_d)
  );

  // Input and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sample_q <= sample_i;
    end
    if (step) begin
      fire_q    <= fire_d;
      ambient_q <= ambient_d;
      total_q   <= total_d;
      calib_q   <= calib_d;
      pulse_q   <= pulse_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign fire_o            = fire_q;
  assign ambient_level_o   = ambient_q;
  assign pulses_seen_o     = total_q;
  assign calibrating_now_o = calib_q;
  assign pulse_active_o    = pulse_q;

  // An accepted word is always held in the input stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_valid_q)
    else $error("accepted word lost");

  // A fire word shows a cleared tally and no open pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fire_o |-> pulses_seen_o == '0 && !pulse_active_o && !calibrating_now_o)
    else $error("inconsistent fire word");

  // A result waiting for its consumer is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !step)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
